// File: src/efc_pkg.sv
// Shared types, codes and constants for the fly camera update block.
// Used by efc_ctrl, efc_dp and euler_fly_camera_update; no dependencies.
`timescale 1ns / 1ps

package efc_pkg;

	localparam logic [1:0] OP_MOVE = 2'd0;
	localparam logic [1:0] OP_TURN = 2'd1;
	localparam logic [1:0] OP_ZOOM = 2'd2;
	localparam logic [1:0] OP_HOME = 2'd3;

	localparam logic [2:0] DIR_FWD   = 3'd0;
	localparam logic [2:0] DIR_BACK  = 3'd1;
	localparam logic [2:0] DIR_UP    = 3'd2;
	localparam logic [2:0] DIR_DOWN  = 3'd3;
	localparam logic [2:0] DIR_LEFT  = 3'd4;
	localparam logic [2:0] DIR_RIGHT = 3'd5;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_START_Z = 2'd2;

	localparam logic [11:0] YAW_HOME    = 12'd2700;
	localparam logic [13:0] FULL_TURN   = 14'd3600;
	localparam logic [13:0] QUARTER     = 14'd900;
	localparam logic [9:0]  QUARTER_R   = 10'd900;
	localparam logic [14:0] FOV_HOME    = 15'd11520;
	localparam logic [14:0] FOV_MIN     = 15'd256;
	localparam logic [14:0] FOV_MAX     = 15'd17920;
	localparam logic [10:0] PITCH_LIMIT = 11'd890;
	localparam logic [15:0] ONE_Q14     = 16'd16384;

	localparam logic [20:0] T_SCALE_HI = 21'd1193046;
	localparam logic [21:0] T_SCALE_LO = 22'd3951998;
	localparam logic signed [31:0] POLY_TOP = 32'sd172272;

	function automatic logic signed [31:0] poly_coef(input logic [1:0] step);
		logic signed [31:0] c;
		case (step)
			2'd0: c = -32'sd5026994;
			2'd1: c = 32'sd85569305;
			2'd2: c = -32'sd693598670;
			default: c = 32'sd1686629713;
		endcase
		return c;
	endfunction

	typedef enum logic [1:0] {
		MUL_TRUNC30,
		MUL_RND14,
		MUL_RND8
	} mul_mode_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_MV_VI,
		DP_MV_VW,
		DP_MV_I,
		DP_MV_W,
		DP_TN_INIT,
		DP_TN_WRAP,
		DP_ZOOM,
		DP_HOME,
		DP_SN_FOLD,
		DP_SN_T,
		DP_SN_T2I,
		DP_SN_T2W,
		DP_SN_HI,
		DP_SN_HW,
		DP_SN_YI,
		DP_SN_YW,
		DP_BS_I,
		DP_BS_W,
		DP_BS_SET,
		DP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MV_VI,
		ST_MV_VW,
		ST_MV_I,
		ST_MV_W,
		ST_TN_INIT,
		ST_TN_WRAP,
		ST_ZOOM,
		ST_HOME,
		ST_SN_FOLD,
		ST_SN_T,
		ST_SN_T2I,
		ST_SN_T2W,
		ST_SN_HI,
		ST_SN_HW,
		ST_SN_YI,
		ST_SN_YW,
		ST_BS_I,
		ST_BS_W,
		ST_BS_SET,
		ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
		logic [1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       dir_ok;
		logic       wrap_done;
		logic       sn_special;
	} dp_stat_t;

endpackage

// File: src/efc_ctrl.sv
// Sequencer for the fly camera update: handshakes and micro-step commands.
// Depends on efc_pkg; drives efc_dp through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module efc_ctrl import efc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic [1:0] step_q, step_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 2'd0;
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		step_d      = step_q;
		out_valid_d = out_valid_q;
		cmd.op      = DP_NOP;
		cmd.idx     = idx_q;
		cmd.step    = step_q;
		in_ready    = 1'b0;
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				idx_d  = 2'd0;
				step_d = 2'd0;
				case (stat.op)
					OP_MOVE: state_d = stat.dir_ok ? ST_MV_VI : ST_DONE;
					OP_TURN: state_d = ST_TN_INIT;
					OP_ZOOM: state_d = ST_ZOOM;
					default: state_d = ST_HOME;
				endcase
			end
			ST_MV_VI: begin
				cmd.op  = DP_MV_VI;
				state_d = ST_MV_VW;
			end
			ST_MV_VW: begin
				cmd.op  = DP_MV_VW;
				state_d = ST_MV_I;
			end
			ST_MV_I: begin
				cmd.op  = DP_MV_I;
				state_d = ST_MV_W;
			end
			ST_MV_W: begin
				cmd.op  = DP_MV_W;
				idx_d   = idx_q + 2'd1;
				state_d = (idx_q == 2'd2) ? ST_DONE : ST_MV_I;
			end
			ST_TN_INIT: begin
				cmd.op  = DP_TN_INIT;
				state_d = ST_TN_WRAP;
			end
			ST_TN_WRAP: begin
				cmd.op = DP_TN_WRAP;
				if (stat.wrap_done)
					state_d = ST_SN_FOLD;
			end
			ST_ZOOM: begin
				cmd.op  = DP_ZOOM;
				state_d = ST_DONE;
			end
			ST_HOME: begin
				cmd.op  = DP_HOME;
				state_d = ST_SN_FOLD;
			end
			ST_SN_FOLD: begin
				cmd.op  = DP_SN_FOLD;
				state_d = ST_SN_T;
			end
			ST_SN_T: begin
				cmd.op = DP_SN_T;
				if (stat.sn_special) begin
					idx_d   = idx_q + 2'd1;
					state_d = (idx_q == 2'd3) ? ST_BS_I : ST_SN_FOLD;
				end else begin
					state_d = ST_SN_T2I;
				end
			end
			ST_SN_T2I: begin
				cmd.op  = DP_SN_T2I;
				state_d = ST_SN_T2W;
			end
			ST_SN_T2W: begin
				cmd.op  = DP_SN_T2W;
				step_d  = 2'd0;
				state_d = ST_SN_HI;
			end
			ST_SN_HI: begin
				cmd.op  = DP_SN_HI;
				state_d = ST_SN_HW;
			end
			ST_SN_HW: begin
				cmd.op  = DP_SN_HW;
				step_d  = step_q + 2'd1;
				state_d = (step_q == 2'd3) ? ST_SN_YI : ST_SN_HI;
			end
			ST_SN_YI: begin
				cmd.op  = DP_SN_YI;
				state_d = ST_SN_YW;
			end
			ST_SN_YW: begin
				cmd.op  = DP_SN_YW;
				idx_d   = idx_q + 2'd1;
				state_d = (idx_q == 2'd3) ? ST_BS_I : ST_SN_FOLD;
			end
			ST_BS_I: begin
				cmd.op  = DP_BS_I;
				state_d = ST_BS_W;
			end
			ST_BS_W: begin
				cmd.op  = DP_BS_W;
				idx_d   = idx_q + 2'd1;
				state_d = (idx_q == 2'd3) ? ST_BS_SET : ST_BS_I;
			end
			ST_BS_SET: begin
				cmd.op  = DP_BS_SET;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = DP_OUT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/efc_dp.sv
// Datapath of the fly camera update: camera state, shared multiplier, sine steps.
// Depends on efc_pkg; commanded by efc_ctrl.
`timescale 1ns / 1ps

module efc_dp import efc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [87:0]        in_data,
	input  logic [1:0]         in_user,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	output logic [207:0]       out_data
);

	// item word
	logic [1:0]         op_q;
	logic [2:0]         dir_q;
	logic [15:0]        speed_q;
	logic [15:0]        dt_q;
	logic signed [15:0] xo_q;
	logic signed [15:0] yo_q;
	logic signed [15:0] zo_q;

	// camera state
	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic [11:0]        yaw_q;
	logic signed [10:0] pitch_q;
	logic [14:0]        fov_q;
	logic signed [15:0] front_x_q, front_y_q, front_z_q;
	logic signed [15:0] right_x_q, right_z_q;
	logic signed [15:0] up_x_q, up_y_q, up_z_q;

	// scratch
	logic [24:0]        vel_q;
	logic signed [16:0] ysum_q;
	logic [9:0]         qa_q;
	logic               neg_q;
	logic [30:0]        t_q;
	logic [30:0]        t2_q;
	logic signed [31:0] acc_q;
	logic signed [15:0] sy_q, cy_q, sp_q, cp_q;
	logic signed [15:0] mcc_q, msc_q, mcs_q, mss_q;
	logic [207:0]       out_q;

	// multiplier
	logic signed [31:0] mul_a, mul_b;
	mul_mode_t          mul_mode;
	logic [31:0]        mag_a, mag_b;
	logic [63:0]        prod_s1;
	logic               neg_s1;
	mul_mode_t          mode_s1;
	logic [63:0]        rnd_add, prod_rnd;
	logic [32:0]        mag_sh;
	logic signed [32:0] mul_res;

	// move
	logic signed [15:0] vec_c;
	logic               mv_neg;
	logic signed [31:0] pos_c;
	logic signed [32:0] disp;
	logic signed [33:0] psum;
	logic signed [31:0] pos_new;

	// turn and zoom
	logic signed [16:0] psum_p;
	logic signed [10:0] pitch_new;
	logic signed [16:0] fsum;
	logic [14:0]        fov_new;

	// sine fold and steps
	logic signed [13:0] ang;
	logic [13:0]        aw;
	logic [1:0]         quad;
	logic [9:0]         rr;
	logic [30:0]        t_hi;
	logic [31:0]        t_lo;
	logic [32:0]        y_pos;
	logic [32:0]        y_rnd;
	logic [15:0]        y_mag;
	logic [15:0]        sn_mag;
	logic signed [15:0] sn_val;

	assign stat.op         = op_q;
	assign stat.dir_ok     = (dir_q <= DIR_RIGHT);
	assign stat.wrap_done  = !ysum_q[16] && (ysum_q < $signed({3'd0, FULL_TURN}));
	assign stat.sn_special = (qa_q == 10'd0) || (qa_q >= QUARTER_R);

	// operand select
	always_comb begin
		case (dir_q)
			DIR_FWD, DIR_BACK: begin
				case (cmd.idx)
					2'd0: vec_c = front_x_q;
					2'd1: vec_c = front_y_q;
					default: vec_c = front_z_q;
				endcase
			end
			DIR_UP, DIR_DOWN: begin
				case (cmd.idx)
					2'd0: vec_c = up_x_q;
					2'd1: vec_c = up_y_q;
					default: vec_c = up_z_q;
				endcase
			end
			default: begin
				case (cmd.idx)
					2'd0: vec_c = right_x_q;
					2'd1: vec_c = 16'sd0;
					default: vec_c = right_z_q;
				endcase
			end
		endcase
		mv_neg = (dir_q == DIR_BACK) || (dir_q == DIR_DOWN) || (dir_q == DIR_LEFT);
	end

	always_comb begin
		mul_a    = 32'sd0;
		mul_b    = 32'sd0;
		mul_mode = MUL_TRUNC30;
		case (cmd.op)
			DP_MV_VI: begin
				mul_a    = $signed({16'd0, speed_q});
				mul_b    = $signed({16'd0, dt_q});
				mul_mode = MUL_RND8;
			end
			DP_MV_I: begin
				mul_a    = {{16{vec_c[15]}}, vec_c};
				mul_b    = $signed({7'd0, vel_q});
				mul_mode = MUL_RND14;
			end
			DP_SN_T2I: begin
				mul_a = $signed({1'b0, t_q});
				mul_b = $signed({1'b0, t_q});
			end
			DP_SN_HI: begin
				mul_a = acc_q;
				mul_b = $signed({1'b0, t2_q});
			end
			DP_SN_YI: begin
				mul_a = acc_q;
				mul_b = $signed({1'b0, t_q});
			end
			DP_BS_I: begin
				mul_mode = MUL_RND14;
				case (cmd.idx)
					2'd0: begin
						mul_a = {{16{cy_q[15]}}, cy_q};
						mul_b = {{16{cp_q[15]}}, cp_q};
					end
					2'd1: begin
						mul_a = {{16{sy_q[15]}}, sy_q};
						mul_b = {{16{cp_q[15]}}, cp_q};
					end
					2'd2: begin
						mul_a = {{16{cy_q[15]}}, cy_q};
						mul_b = {{16{sp_q[15]}}, sp_q};
					end
					default: begin
						mul_a = {{16{sy_q[15]}}, sy_q};
						mul_b = {{16{sp_q[15]}}, sp_q};
					end
				endcase
			end
			default: ;
		endcase
		mag_a = mul_a[31] ? (~mul_a + 32'd1) : mul_a;
		mag_b = mul_b[31] ? (~mul_b + 32'd1) : mul_b;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= {32'd0, mag_a} * {32'd0, mag_b};
		neg_s1  <= mul_a[31] ^ mul_b[31];
		mode_s1 <= mul_mode;
	end

	always_comb begin
		case (mode_s1)
			MUL_RND14: rnd_add = 64'd8192;
			MUL_RND8:  rnd_add = 64'd128;
			default:   rnd_add = 64'd0;
		endcase
		prod_rnd = prod_s1 + rnd_add;
		case (mode_s1)
			MUL_RND14: mag_sh = prod_rnd[46:14];
			MUL_RND8:  mag_sh = prod_rnd[40:8];
			default:   mag_sh = prod_rnd[62:30];
		endcase
		mul_res = neg_s1 ? $signed(~mag_sh + 33'd1) : $signed(mag_sh);
	end

	// saturating position update
	always_comb begin
		case (cmd.idx)
			2'd0: pos_c = pos_x_q;
			2'd1: pos_c = pos_y_q;
			default: pos_c = pos_z_q;
		endcase
		disp = mv_neg ? -mul_res : mul_res;
		psum = {{2{pos_c[31]}}, pos_c} + {disp[32], disp};
		if (!psum[33] && (psum[32:31] != 2'b00))
			pos_new = 32'sh7FFF_FFFF;
		else if (psum[33] && (psum[32:31] != 2'b11))
			pos_new = 32'sh8000_0000;
		else
			pos_new = psum[31:0];
	end

	// pitch and zoom clamps
	always_comb begin
		psum_p = {{6{pitch_q[10]}}, pitch_q} + {yo_q[15], yo_q};
		if (psum_p > $signed({6'd0, PITCH_LIMIT}))
			pitch_new = $signed(PITCH_LIMIT);
		else if (psum_p < -$signed({6'd0, PITCH_LIMIT}))
			pitch_new = -$signed(PITCH_LIMIT);
		else
			pitch_new = psum_p[10:0];
		fsum = $signed({2'd0, fov_q}) + {zo_q[15], zo_q};
		if (fsum < $signed({2'd0, FOV_MIN}))
			fov_new = FOV_MIN;
		else if (fsum > $signed({2'd0, FOV_MAX}))
			fov_new = FOV_MAX;
		else
			fov_new = fsum[14:0];
	end

	// quarter-wave fold
	always_comb begin
		case (cmd.idx)
			2'd0: ang = $signed({2'b00, yaw_q});
			2'd1: ang = $signed({2'b00, yaw_q} + QUARTER);
			2'd2: ang = {{3{pitch_q[10]}}, pitch_q};
			default: ang = $signed({{3{pitch_q[10]}}, pitch_q} + QUARTER);
		endcase
		if (ang[13])
			aw = ang + FULL_TURN;
		else if (ang >= $signed(FULL_TURN))
			aw = ang - FULL_TURN;
		else
			aw = ang;
		if (aw >= 14'd2700) begin
			quad = 2'd3;
			rr   = 10'(aw - 14'd2700);
		end else if (aw >= 14'd1800) begin
			quad = 2'd2;
			rr   = 10'(aw - 14'd1800);
		end else if (aw >= QUARTER) begin
			quad = 2'd1;
			rr   = 10'(aw - QUARTER);
		end else begin
			quad = 2'd0;
			rr   = aw[9:0];
		end
	end

	// Q30 phase, final rounding to Q14
	always_comb begin
		t_hi   = {21'd0, qa_q} * {10'd0, T_SCALE_HI};
		t_lo   = {22'd0, qa_q} * {10'd0, T_SCALE_LO};
		y_pos  = mul_res[32] ? 33'd0 : mul_res;
		y_rnd  = (y_pos + 33'd32768) >> 16;
		y_mag  = (y_rnd > {17'd0, ONE_Q14}) ? ONE_Q14 : y_rnd[15:0];
		if (cmd.op == DP_SN_YW)
			sn_mag = y_mag;
		else
			sn_mag = (qa_q == 10'd0) ? 16'd0 : ONE_Q14;
		sn_val = neg_q ? -$signed(sn_mag) : $signed(sn_mag);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				op_q    <= in_user;
				dir_q   <= in_data[2:0];
				speed_q <= in_data[18:3];
				dt_q    <= in_data[34:19];
				xo_q    <= in_data[50:35];
				yo_q    <= in_data[66:51];
				zo_q    <= in_data[82:67];
			end
			DP_MV_VW:   vel_q <= mul_res[24:0];
			DP_TN_INIT: ysum_q <= $signed({5'd0, yaw_q}) + {xo_q[15], xo_q};
			DP_TN_WRAP: begin
				if (ysum_q[16])
					ysum_q <= ysum_q + $signed({3'd0, FULL_TURN});
				else if (!stat.wrap_done)
					ysum_q <= ysum_q - $signed({3'd0, FULL_TURN});
			end
			DP_SN_FOLD: begin
				qa_q  <= quad[0] ? (QUARTER_R - rr) : rr;
				neg_q <= quad[1];
			end
			DP_SN_T: t_q <= t_hi + {22'd0, t_lo[31:23]};
			DP_SN_T2W: begin
				t2_q  <= mul_res[30:0];
				acc_q <= POLY_TOP;
			end
			DP_SN_HW: acc_q <= poly_coef(cmd.step) + mul_res[31:0];
			DP_BS_W: begin
				case (cmd.idx)
					2'd0: mcc_q <= mul_res[15:0];
					2'd1: msc_q <= mul_res[15:0];
					2'd2: mcs_q <= mul_res[15:0];
					default: mss_q <= mul_res[15:0];
				endcase
			end
			DP_OUT: out_q <= {1'b0, fov_q, up_z_q, up_y_q, up_x_q,
				front_z_q, front_y_q, front_x_q, pos_z_q, pos_y_q, pos_x_q};
			default: ;
		endcase
		if ((cmd.op == DP_SN_YW) || ((cmd.op == DP_SN_T) && stat.sn_special)) begin
			case (cmd.idx)
				2'd0: sy_q <= sn_val;
				2'd1: cy_q <= sn_val;
				2'd2: sp_q <= sn_val;
				default: cp_q <= sn_val;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 32'sd0;
			pos_y_q   <= 32'sd0;
			pos_z_q   <= 32'sd0;
			yaw_q     <= YAW_HOME;
			pitch_q   <= 11'sd0;
			fov_q     <= FOV_HOME;
			front_x_q <= 16'sd0;
			front_y_q <= 16'sd0;
			front_z_q <= -$signed(ONE_Q14);
			right_x_q <= $signed(ONE_Q14);
			right_z_q <= 16'sd0;
			up_x_q    <= 16'sd0;
			up_y_q    <= $signed(ONE_Q14);
			up_z_q    <= 16'sd0;
		end else begin
			case (cmd.op)
				DP_MV_W: begin
					case (cmd.idx)
						2'd0: pos_x_q <= pos_new;
						2'd1: pos_y_q <= pos_new;
						default: pos_z_q <= pos_new;
					endcase
				end
				DP_TN_INIT: pitch_q <= pitch_new;
				DP_TN_WRAP: begin
					if (stat.wrap_done)
						yaw_q <= ysum_q[11:0];
				end
				DP_ZOOM: fov_q <= fov_new;
				DP_HOME: begin
					pos_x_q <= start_x;
					pos_y_q <= start_y;
					pos_z_q <= start_z;
					yaw_q   <= YAW_HOME;
					pitch_q <= 11'sd0;
				end
				DP_BS_SET: begin
					front_x_q <= mcc_q;
					front_y_q <= sp_q;
					front_z_q <= msc_q;
					right_x_q <= -sy_q;
					right_z_q <= cy_q;
					up_x_q    <= -mcs_q;
					up_y_q    <= cp_q;
					up_z_q    <= -mss_q;
				end
				default: ;
			endcase
		end
	end

	assign out_data = out_q;

endmodule

// File: src/euler_fly_camera_update.sv
// Top level of the fly camera update: stream ports, APB start-pose registers.
// Depends on efc_pkg, efc_ctrl and efc_dp.
//
//  channel  | direction | words
//  s_axis   | in        | one command word per item
//  m_axis   | out       | one camera state word per item
//  apb      | in/out    | start_x, start_y, start_z at 0x0, 0x4, 0x8
//
// A turn runs a yaw wrap, four sine evaluations on one shared 32x32
// multiplier and the basis products; home runs the same sine and basis
// steps. One word is in flight at a time; the result
// waits in an output register. A stalled m_axis holds the word and the
// controller in its final state. arst_n clears the camera to its home pose.
`timescale 1ns / 1ps

module euler_fly_camera_update import efc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// direction[2:0], speed[18:3], delta_time[34:19], x_offset[50:35],
	// y_offset[66:51], zoom_amount[82:67], zero pad
	input  logic [87:0]  s_axis_tdata,
	// op[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], front_x[111:96],
	// front_y[127:112], front_z[143:128], up_x[159:144], up_y[175:160],
	// up_z[191:176], field_of_view[206:192], zero pad
	output logic [207:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic signed [31:0] start_x_q, start_y_q, start_z_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= 32'sd0;
			start_y_q <= 32'sd0;
			start_z_q <= 32'sd0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_START_X: start_x_q <= pwdata;
				REG_START_Y: start_y_q <= pwdata;
				REG_START_Z: start_z_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_X: prdata = start_x_q;
			REG_START_Y: prdata = start_y_q;
			REG_START_Z: prdata = start_z_q;
			default: prdata = 32'd0;
		endcase
	end

	efc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	efc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.start_x  (start_x_q),
		.start_y  (start_y_q),
		.start_z  (start_z_q),
		.out_data (m_axis_tdata)
	);

endmodule

// File: tb/euler_fly_camera_update_test.sv
// Self-checking bench for the fly camera update: directed and random words in,
// predicted camera state compared word by word. Depends on efc_pkg and the RTL.
`timescale 1ns / 1ps

module euler_fly_camera_update_test;
	import efc_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] dir;
		logic [15:0] speed;
		logic [15:0] dt;
		logic signed [15:0] xo;
		logic signed [15:0] yo;
		logic signed [15:0] zoom;
	} cmd_t;

	typedef struct packed {
		logic [14:0] fov;
		logic [15:0] uz, uy, ux, fz, fy, fx;
		logic [31:0] pz, py, px;
	} cam_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [207:0] m_axis_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	euler_fly_camera_update dut (.*);

	always #4 clk = ~clk;

	cmd_t pending_cmds[$];
	cam_t expected_cams[$];
	int errors = 0, mismatches = 0, words_in = 0, words_out = 0, idle_cycles = 0;
	int send_wait = 0, recv_wait = 0, hold_off = 0;
	bit hold_req = 0;

	// camera state mirror
	longint home_pos[3];
	longint cam_pos[3];
	int yaw, pitch, fov;
	int fv[3], rv[3], uv[3];

	function automatic longint mul_sh(longint a, longint b, int sh, bit rnd);
		bit neg;
		longint p;
		neg = (a < 0) != (b < 0);
		p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
		if (rnd) p += longint'(1) << (sh - 1);
		p = p >>> sh;
		return neg ? -p : p;
	endfunction

	function automatic int quarter_sin(int r);
		longint t, t2, p, y;
		if (r >= 900) return 16384;
		if (r <= 0) return 0;
		t = (longint'(r) << 30) / 900;
		t2 = mul_sh(t, t, 30, 0);
		p = 172272;
		p = -5026994 + mul_sh(p, t2, 30, 0);
		p = 85569305 + mul_sh(p, t2, 30, 0);
		p = -693598670 + mul_sh(p, t2, 30, 0);
		p = 1686629713 + mul_sh(p, t2, 30, 0);
		y = mul_sh(p, t, 30, 0);
		if (y < 0) y = 0;
		y = (y + 32768) / 65536;
		if (y > 16384) y = 16384;
		return int'(y);
	endfunction

	function automatic int sin_tenths(int a);
		int q, r, m;
		a = a % 3600;
		if (a < 0) a += 3600;
		q = a / 900;
		r = a % 900;
		m = quarter_sin((q & 1) ? 900 - r : r);
		return q >= 2 ? -m : m;
	endfunction

	function automatic void set_basis();
		int sy, cy, sp, cp;
		sy = sin_tenths(yaw); cy = sin_tenths(yaw + 900);
		sp = sin_tenths(pitch); cp = sin_tenths(pitch + 900);
		fv[0] = int'(mul_sh(cy, cp, 14, 1)); fv[1] = sp; fv[2] = int'(mul_sh(sy, cp, 14, 1));
		rv[0] = -sy; rv[1] = 0; rv[2] = cy;
		uv[0] = -int'(mul_sh(cy, sp, 14, 1)); uv[1] = cp;
		uv[2] = -int'(mul_sh(sy, sp, 14, 1));
	endfunction

	function automatic void camera_reset();
		for (int i = 0; i < 3; i++) begin
			home_pos[i] = 0; cam_pos[i] = 0;
		end
		yaw = 2700; pitch = 0; fov = 11520;
		fv = '{0, 0, -16384}; rv = '{16384, 0, 0}; uv = '{0, 16384, 0};
	endfunction

	function automatic cam_t camera_step(cmd_t c);
		cam_t o;
		longint vel, d, s, t;
		int v[3];
		bit neg, ok;
		case (c.op)
			OP_MOVE: begin
				ok = 1;
				case (c.dir)
					DIR_FWD: begin v = fv; neg = 0; end
					DIR_BACK: begin v = fv; neg = 1; end
					DIR_UP: begin v = uv; neg = 0; end
					DIR_DOWN: begin v = uv; neg = 1; end
					DIR_LEFT: begin v = rv; neg = 1; end
					DIR_RIGHT: begin v = rv; neg = 0; end
					default: ok = 0;
				endcase
				if (ok) begin
					vel = (longint'(c.speed) * longint'(c.dt) + 128) >>> 8;
					for (int i = 0; i < 3; i++) begin
						d = mul_sh(v[i], vel, 14, 1);
						s = cam_pos[i] + (neg ? -d : d);
						if (s > 64'sd2147483647) s = 64'sd2147483647;
						if (s < -64'sd2147483648) s = -64'sd2147483648;
						cam_pos[i] = s;
					end
				end
			end
			OP_TURN: begin
				t = (longint'(yaw) + longint'(c.xo)) % 3600;
				if (t < 0) t += 3600;
				yaw = int'(t);
				t = longint'(pitch) + longint'(c.yo);
				if (t > 890) t = 890;
				if (t < -890) t = -890;
				pitch = int'(t);
				set_basis();
			end
			OP_ZOOM: begin
				t = longint'(fov) + longint'(c.zoom);
				if (t < 256) t = 256;
				if (t > 17920) t = 17920;
				fov = int'(t);
			end
			default: begin
				cam_pos = home_pos;
				yaw = 2700; pitch = 0;
				set_basis();
			end
		endcase
		o.px = cam_pos[0][31:0]; o.py = cam_pos[1][31:0]; o.pz = cam_pos[2][31:0];
		o.fx = fv[0][15:0]; o.fy = fv[1][15:0]; o.fz = fv[2][15:0];
		o.ux = uv[0][15:0]; o.uy = uv[1][15:0]; o.uz = uv[2][15:0];
		o.fov = fov[14:0];
		return o;
	endfunction

	// sender
	always @(posedge clk) begin
		cmd_t c;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_cams.push_back(camera_step(pending_cmds.pop_front()));
			words_in++;
			send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
			s_axis_tvalid <= 0;
		end else if (!s_axis_tvalid && pending_cmds.size() > 0) begin
			if (send_wait > 0) send_wait <= send_wait - 1;
			else begin
				c = pending_cmds[0];
				s_axis_tdata <= {5'b0, c.zoom, c.yo, c.xo, c.dt, c.speed, c.dir};
				s_axis_tuser <= c.op;
				s_axis_tvalid <= 1;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		cam_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[206:0];
			words_out++;
			if (expected_cams.size() == 0) begin
				errors++;
				$display("unexpected word %h", got);
			end else begin
				want = expected_cams.pop_front();
				if (got !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch word %0d: expected %h got %h",
							words_out, want, got);
				end
			end
		end
		if (hold_req && hold_off == 0) hold_off <= 300;
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 0;
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			m_axis_tready <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
			m_axis_tready <= 0;
		end else m_axis_tready <= 1;
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_home(int idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		home_pos[idx] = longint'($signed(val));
	endtask

	task automatic drain();
		wait (pending_cmds.size() == 0 && !s_axis_tvalid && expected_cams.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	function automatic cmd_t rand_cmd(logic [1:0] op);
		cmd_t c;
		c.op = op;
		c.dir = $urandom_range(0, 7);
		c.speed = $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom;
		c.dt = $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom;
		c.xo = $urandom_range(0, 1) ? $urandom_range(0, 200) - 100 : $urandom;
		c.yo = $urandom_range(0, 1) ? $urandom_range(0, 200) - 100 : $urandom;
		c.zoom = $urandom_range(0, 1) ? $urandom_range(0, 2000) - 1000 : $urandom;
		return c;
	endfunction

	function automatic cmd_t mk(logic [1:0] op, logic [2:0] dir, logic [15:0] sp,
			logic [15:0] dt, logic [15:0] xo, logic [15:0] yo, logic [15:0] z);
		cmd_t c;
		c.op = op; c.dir = dir; c.speed = sp; c.dt = dt; c.xo = xo; c.yo = yo; c.zoom = z;
		return c;
	endfunction

	initial begin
		logic [31:0] extremes[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h12345678};
		camera_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		for (int i = 0; i < 3; i++) write_home(i, extremes[i]);
		pending_cmds.push_back(mk(OP_HOME, 0, 0, 0, 0, 0, 0));
		for (int d = 0; d < 8; d++)
			pending_cmds.push_back(mk(OP_MOVE, d, 16'hFFFF, 16'hFFFF, 0, 0, 0));
		pending_cmds.push_back(mk(OP_TURN, 0, 0, 0, 16'h7FFF, 16'h7FFF, 0));
		pending_cmds.push_back(mk(OP_TURN, 0, 0, 0, 16'h8000, 16'h8000, 0));
		pending_cmds.push_back(mk(OP_TURN, 0, 0, 0, 900, 890, 0));
		pending_cmds.push_back(mk(OP_MOVE, DIR_UP, 16'hFFFF, 16'hFFFF, 0, 0, 0));
		pending_cmds.push_back(mk(OP_TURN, 0, 0, 0, -16'sd3600, 16'hFFFF, 0));
		pending_cmds.push_back(mk(OP_ZOOM, 0, 0, 0, 0, 0, 16'h7FFF));
		pending_cmds.push_back(mk(OP_ZOOM, 0, 0, 0, 0, 0, 16'h8000));
		pending_cmds.push_back(mk(OP_ZOOM, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(OP_MOVE, DIR_FWD, 0, 16'hFFFF, 0, 0, 0));
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 3; i++)
				write_home(i, ph == 3 ? extremes[(i + 1) % 4] : $urandom);
			for (int n = 0; n < 245; n++)
				pending_cmds.push_back(rand_cmd($urandom_range(0, 3)));
			if (ph == 1) begin
				hold_req <= 1;
				@(posedge clk);
				hold_req <= 0;
			end
			drain();
		end
		$display("covered %0d words over five home-pose settings, all ops and directions",
			words_in);
		if (errors == 0 && expected_cams.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// File: filelist.f
src/efc_pkg.sv
src/efc_ctrl.sv
src/efc_dp.sv
src/euler_fly_camera_update.sv
tb/euler_fly_camera_update_test.sv
